@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of i_clk, suspended while reset is low.
`define ALM_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Concurrent check on the rising edge of i_clk, active during reset too.
`define ALM_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ rtl/alm_pkg.sv @@
`timescale 1ns / 1ps

package alm_pkg;

    // Defaults for the top-level parameters
    localparam int RECORD_COUNT_DEF = 256;
    localparam int DOOR_COUNT_DEF   = 8;

    // Fixed field widths
    localparam int INDEX_W  = 8;
    localparam int DOOR_W   = 8;
    localparam int DOORNUM_W = 3;
    localparam int CARD_W   = 32;
    localparam int PIN_W    = 32;
    localparam int KIND_W   = 3;

    // Opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // Request kinds
    localparam logic [1:0] REQ_PIN     = 2'd0;
    localparam logic [1:0] REQ_CARD    = 2'd1;
    localparam logic [1:0] REQ_BOTH    = 2'd2;
    localparam logic [1:0] REQ_INVALID = 2'd3;

    // Stored pin kinds
    localparam logic [1:0] PIN_NONE  = 2'd0;
    localparam logic [1:0] PIN_FIXED = 2'd1;
    localparam logic [1:0] PIN_ONCE  = 2'd2;
    localparam logic [1:0] PIN_TIMED = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_WRITTEN = 2'd0;
    localparam logic [1:0] STAT_GRANTED = 2'd1;
    localparam logic [1:0] STAT_DENIED  = 2'd2;
    localparam logic [1:0] STAT_INVALID = 2'd3;

    typedef struct packed {
        logic       card_kind;
        logic [1:0] pin_kind;
    } t_cred_kind;

    typedef struct packed {
        logic [1:0]           kind;
        logic [DOORNUM_W-1:0] door;
        logic [CARD_W-1:0]    card;
        logic [PIN_W-1:0]     pin;
    } t_request;

endpackage

@@ rtl/alm_match.sv @@
`timescale 1ns / 1ps

module alm_match import alm_pkg::*; #(
    parameter int DOOR_COUNT = DOOR_COUNT_DEF
) (
    input  logic [DOOR_COUNT-1:0] i_doors,
    input  t_cred_kind            i_kind,
    input  logic [CARD_W-1:0]     i_card_q,
    input  logic [PIN_W-1:0]      i_pin_q,
    input  t_request              i_req,
    output logic                  o_hit
);

    logic [DOOR_W-1:0] doors_ext;
    logic              door_hit;
    logic              has_card;
    logic              has_pin;
    logic              kind_fits;
    logic              card_ok;
    logic              pin_ok;

    assign doors_ext = DOOR_W'(i_doors);
    assign door_hit  = doors_ext[i_req.door];
    assign has_card  = i_kind.card_kind;
    assign has_pin   = (i_kind.pin_kind != PIN_NONE);

    always_comb begin
        case (i_req.kind)
            REQ_PIN:  kind_fits = !has_card && has_pin;
            REQ_CARD: kind_fits = has_card && !has_pin;
            default:  kind_fits = has_card && has_pin;
        endcase
    end

    assign card_ok = has_card ? (i_req.card == i_card_q) : (i_req.card == '0);

    // One-time and time-based pins never match
    always_comb begin
        case (i_kind.pin_kind)
            PIN_NONE:  pin_ok = (i_req.pin == '0);
            PIN_FIXED: pin_ok = (i_req.pin == i_pin_q);
            default:   pin_ok = 1'b0;
        endcase
    end

    assign o_hit = door_hit && kind_fits && card_ok && pin_ok;

endmodule

@@ rtl/access_list_matcher.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Door access list: a write transaction stores one record (door mask,
// credential kind, card, pin) and clears its used mark; a check transaction
// scans the records from index 0 upward and grants on the first one whose
// door mask, credential kind, card and pin all fit, setting its used mark.
// Records live in two simple dual-port synchronous memories (one read and one
// write per cycle, registered read data); the scan reads one entry per
// cycle. A write, an invalid request kind or a door number at or above
// DOOR_COUNT completes in the accept cycle. A check holds the input stalled
// while it scans the record memory up to a grant or the last entry and until
// its result has moved to the output register. After reset a clearing pass
// over all RECORD_COUNT entries empties the door masks and used marks; no
// transaction is taken during it. One transaction is in work at a time; the
// result waits in an output register while the next transaction is taken,
// unless the output side stalls.
module access_list_matcher import alm_pkg::*; #(
    parameter int RECORD_COUNT = RECORD_COUNT_DEF,
    parameter int DOOR_COUNT   = DOOR_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_opcode,
    input  logic [INDEX_W-1:0]   i_record_index,
    input  logic [DOOR_W-1:0]    i_record_doors,
    input  logic                 i_record_card_kind,
    input  logic [1:0]           i_record_pin_kind,
    input  logic [CARD_W-1:0]    i_record_card,
    input  logic [PIN_W-1:0]     i_record_pin,
    input  logic [1:0]           i_request_kind,
    input  logic [DOORNUM_W-1:0] i_door,
    input  logic [CARD_W-1:0]    i_card_id,
    input  logic [PIN_W-1:0]     i_pin_code,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_status,
    output logic [INDEX_W-1:0]   o_matched_index,
    output logic                 o_first_use
);

    localparam int IDX_W  = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1;
    localparam int META_W = DOOR_COUNT + KIND_W + 1;  // {used, kind, doors}
    localparam int CRED_W = CARD_W + PIN_W;           // {card, pin}
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RECORD_COUNT - 1);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    // Record storage: metadata is cleared after reset, credentials are not
    logic [META_W-1:0] r_meta_mem [RECORD_COUNT];
    logic [CRED_W-1:0] r_cred_mem [RECORD_COUNT];
    logic [META_W-1:0] r_meta_q;
    logic [CRED_W-1:0] r_cred_q;

    logic [1:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_clr_addr, n_clr_addr;
    logic [IDX_W-1:0]  r_scan_addr, n_scan_addr;
    logic [IDX_W-1:0]  r_eval_idx, n_eval_idx;
    logic              r_pend, n_pend;
    logic [1:0]        r_res_status, n_res_status;
    logic [INDEX_W-1:0] r_res_idx, n_res_idx;
    logic              r_res_first, n_res_first;
    t_request          r_req, n_req;

    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic [INDEX_W-1:0] r_out_idx;
    logic              r_out_first;

    logic              accept;
    logic              out_free;
    logic              load_out;
    logic [1:0]        out_status;
    logic [INDEX_W-1:0] out_idx;
    logic              out_first;

    logic              meta_we;
    logic [IDX_W-1:0]  meta_wa;
    logic [META_W-1:0] meta_wd;
    logic              cred_we;
    logic [IDX_W-1:0]  wr_addr;
    logic              index_ok;
    logic              door_ok;
    logic              hit;
    t_request          in_req;
    t_cred_kind        in_kind;
    t_cred_kind        q_kind;

    // Handshake: take a transaction only when idle and the output register
    // is empty or draining this cycle
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE) || !out_free;
    assign accept   = i_valid && !o_stall;

    assign in_req.kind = i_request_kind;
    assign in_req.door = i_door;
    assign in_req.card = i_card_id;
    assign in_req.pin  = i_pin_code;

    assign in_kind.card_kind = i_record_card_kind;
    assign in_kind.pin_kind  = i_record_pin_kind;

    assign wr_addr  = IDX_W'(i_record_index);
    assign index_ok = (32'(i_record_index) < RECORD_COUNT);
    assign door_ok  = (32'(i_door) < DOOR_COUNT);

    assign q_kind = t_cred_kind'(r_meta_q[DOOR_COUNT +: KIND_W]);

    alm_match #(
        .DOOR_COUNT (DOOR_COUNT)
    ) u_match (
        .i_doors  (r_meta_q[DOOR_COUNT-1:0]),
        .i_kind   (q_kind),
        .i_card_q (r_cred_q[CRED_W-1 -: CARD_W]),
        .i_pin_q  (r_cred_q[PIN_W-1:0]),
        .i_req    (r_req),
        .o_hit    (hit)
    );

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_scan_addr  = r_scan_addr;
        n_eval_idx   = r_eval_idx;
        n_pend       = r_pend;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_res_first  = r_res_first;
        n_req        = r_req;
        meta_we      = 1'b0;
        meta_wa      = r_eval_idx;
        meta_wd      = {1'b1, r_meta_q[META_W-2:0]};
        cred_we      = 1'b0;
        load_out     = 1'b0;
        out_status   = STAT_WRITTEN;
        out_idx      = '0;
        out_first    = 1'b0;

        case (r_state)
            S_CLEAR: begin
                // Empty one entry per cycle: zero door mask, used mark clear
                meta_we = 1'b1;
                meta_wa = r_clr_addr;
                meta_wd = '0;
                if (r_clr_addr == LAST_IDX) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + IDX_W'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_req = in_req;
                    if (i_opcode == OP_WRITE) begin
                        // Store the record and clear its used mark; drop
                        // writes beyond the table
                        meta_we  = index_ok;
                        cred_we  = index_ok;
                        meta_wa  = wr_addr;
                        meta_wd  = {1'b0, in_kind, i_record_doors[DOOR_COUNT-1:0]};
                        load_out = 1'b1;
                    end else if (i_request_kind == REQ_INVALID) begin
                        load_out   = 1'b1;
                        out_status = STAT_INVALID;
                    end else if (!door_ok) begin
                        load_out   = 1'b1;
                        out_status = STAT_DENIED;
                    end else begin
                        n_state     = S_SCAN;
                        n_scan_addr = '0;
                        n_pend      = 1'b0;
                    end
                end
            end
            S_SCAN: begin
                // Issue one read per cycle; hold the address at the last entry
                n_pend     = 1'b1;
                n_eval_idx = r_scan_addr;
                if (r_scan_addr != LAST_IDX) begin
                    n_scan_addr = r_scan_addr + IDX_W'(1);
                end
                if (r_pend) begin
                    if (hit) begin
                        // Write back the entry with its used mark set
                        meta_we      = 1'b1;
                        n_res_status = STAT_GRANTED;
                        n_res_idx    = INDEX_W'(r_eval_idx);
                        n_res_first  = !r_meta_q[META_W-1];
                        n_state      = S_RESULT;
                    end else if (r_eval_idx == LAST_IDX) begin
                        n_res_status = STAT_DENIED;
                        n_res_idx    = '0;
                        n_res_first  = 1'b0;
                        n_state      = S_RESULT;
                    end
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    out_status = r_res_status;
                    out_idx    = r_res_idx;
                    out_first  = r_res_first;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_scan_addr <= '0;
            r_eval_idx  <= '0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_scan_addr <= n_scan_addr;
            r_eval_idx  <= n_eval_idx;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_res_first  <= n_res_first;
        r_req        <= n_req;
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_status <= out_status;
            r_out_idx    <= out_idx;
            r_out_first  <= out_first;
        end
    end

    // Record memories; the scan always reads at the scan address
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_mem[meta_wa] <= meta_wd;
        end
        r_meta_q <= r_meta_mem[r_scan_addr];
    end

    always_ff @(posedge i_clk) begin
        if (cred_we) begin
            r_cred_mem[wr_addr] <= {i_record_card, i_record_pin};
        end
        r_cred_q <= r_cred_mem[r_scan_addr];
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_matched_index = r_out_idx;
    assign o_first_use     = r_out_first;

    `ALM_ASSERT(a_hit_writes_back, (r_state == S_SCAN && r_pend && hit) |-> (meta_we && meta_wa == r_eval_idx && meta_wd[META_W-1]), "granting entry not written back with used mark")
    `ALM_ASSERT(a_eval_in_table, (r_state == S_SCAN && r_pend) |-> (r_eval_idx <= LAST_IDX), "scan evaluated an entry beyond the table")
    `ALM_ASSERT(a_result_drains, (r_state == S_RESULT && out_free) |=> (r_out_valid && r_state == S_IDLE), "pending result not moved to the output register")
    `ALM_ASSERT(a_denied_clean, (r_out_valid && r_out_status != STAT_GRANTED) |-> (r_out_idx == '0 && !r_out_first), "non-grant result carries an index or first-use flag")

endmodule
